@@ rtl/jsof_pkg.sv @@
// ----------------------------------------------------------------------------
// jsof_pkg
// Shared types and marker codes for the JPEG frame header component finder.
// ----------------------------------------------------------------------------
package jsof_pkg;

    localparam logic [7:0]  MARK_PREFIX   = 8'hFF;
    localparam logic [7:0]  MARK_SOF0     = 8'hC0;
    localparam logic [7:0]  MARK_SOF3     = 8'hC3;
    localparam logic [7:0]  MARK_SOI      = 8'hD8;
    localparam logic [7:0]  MARK_EOI      = 8'hD9;
    localparam logic [7:0]  MARK_RST0     = 8'hD0;
    localparam logic [7:0]  MARK_RST7     = 8'hD7;
    localparam logic [7:0]  MARK_TEM      = 8'h01;
    localparam logic [3:0]  SOF_COUNT_OFS = 4'd9;
    localparam logic [3:0]  SOF_DONE_OFS  = 4'd10;
    localparam logic [15:0] MIN_SEG_LEN   = 16'd2;
    localparam logic [7:0]  COLOR_MIN     = 8'd3;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_MARKER,
        PH_LENHI,
        PH_LENLO,
        PH_SKIP,
        PH_SOF,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] component_count;
        logic       is_color;
        logic       sof_found;
    } t_result;

endpackage

@@ rtl/jsof_ifs.sv @@
// ----------------------------------------------------------------------------
// jsof_ifs
// Valid/ready channels for stream bytes in and component results out.
// ----------------------------------------------------------------------------
interface jsof_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jsof_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] component_count;
    logic       is_color;
    logic       sof_found;

    modport source (output valid, output component_count, output is_color,
                    output sof_found, input ready);
    modport sink   (input valid, input component_count, input is_color,
                    input sof_found, output ready);
endinterface

@@ rtl/jsof_in_stage.sv @@
// ----------------------------------------------------------------------------
// jsof_in_stage
// Input register for stream bytes; holds one item until the scanner takes it.
// ----------------------------------------------------------------------------
module jsof_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output logic       o_ready,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_data,
    output logic       o_last
);
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
            r_last <= i_last;
        end
    end

endmodule

@@ rtl/jsof_scan.sv @@
// ----------------------------------------------------------------------------
// jsof_scan
// Marker walker: per-byte state update and result generation.
// ----------------------------------------------------------------------------
module jsof_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_data,
    input  logic              i_last,
    output logic              o_res_valid,
    output jsof_pkg::t_result o_res
);
    import jsof_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_skip, n_skip;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [3:0]  r_off, n_off;
    logic [7:0]  r_count, n_count;

    logic [15:0] seg_len;
    logic [3:0]  off_inc;
    logic        scan_res;
    t_result     scan_val;

    assign seg_len = {r_len_hi, i_data};
    assign off_inc = r_off + 4'd1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HUNT: begin
                if (i_data == MARK_PREFIX) n_phase = PH_MARKER;
            end
            PH_MARKER: begin
                if (i_data inside {[MARK_SOF0:MARK_SOF3]}) begin
                    n_phase = PH_SOF;
                end else if (i_data inside {MARK_SOI, MARK_EOI, [MARK_RST0:MARK_RST7],
                                            MARK_TEM}) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_phase = PH_LENHI;
                end
            end
            PH_LENHI: n_phase = PH_LENLO;
            PH_LENLO: begin
                if (seg_len < MIN_SEG_LEN) begin
                    n_phase = PH_DONE;
                end else if (seg_len == MIN_SEG_LEN) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (r_skip == 16'd1) n_phase = PH_HUNT;
            end
            PH_SOF: begin
                if (off_inc >= SOF_DONE_OFS) n_phase = PH_DONE;
            end
            PH_DONE: n_phase = PH_DONE;
            default: n_phase = PH_DONE;
        endcase
        if (i_last) n_phase = PH_HUNT;
    end

    // datapath and result
    always_comb begin
        n_skip   = r_skip;
        n_len_hi = r_len_hi;
        n_off    = r_off;
        n_count  = r_count;
        scan_res = 1'b0;
        scan_val = '0;
        case (r_phase)
            PH_MARKER: begin
                if (i_data inside {[MARK_SOF0:MARK_SOF3]}) n_off = 4'd1;
            end
            PH_LENHI: n_len_hi = i_data;
            PH_LENLO: begin
                if (seg_len < MIN_SEG_LEN) begin
                    scan_res = 1'b1;
                end else begin
                    n_skip = seg_len - MIN_SEG_LEN;
                end
            end
            PH_SKIP: n_skip = r_skip - 16'd1;
            PH_SOF: begin
                n_off = off_inc;
                if (off_inc == SOF_COUNT_OFS) begin
                    n_count = i_data;
                end else if (off_inc >= SOF_DONE_OFS) begin
                    scan_res                 = 1'b1;
                    scan_val.component_count = r_count;
                    scan_val.is_color        = (r_count >= COLOR_MIN);
                    scan_val.sof_found       = 1'b1;
                end
            end
            default: ;
        endcase
        if (i_last) begin
            n_skip   = '0;
            n_len_hi = '0;
            n_off    = '0;
            n_count  = '0;
            if (r_phase != PH_DONE) scan_res = 1'b1;
        end
    end

    assign o_res_valid = i_fire && scan_res;
    assign o_res       = scan_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_skip   <= '0;
            r_len_hi <= '0;
            r_off    <= '0;
            r_count  <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_len_hi <= n_len_hi;
            r_off    <= n_off;
            r_count  <= n_count;
        end
    end

    a_res_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_fire)
        else $error("result without an item");

    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_last) |=> (r_phase == PH_HUNT && r_off == 4'd0 && r_skip == 16'd0))
        else $error("scanner not rearmed after last byte");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && !i_last) |-> !o_res_valid)
        else $error("second result for one stream");

    a_found_from_sof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.sof_found) |-> r_phase == PH_SOF)
        else $error("frame header result outside header");

    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && !(i_fire && i_last)) |=> r_phase == PH_DONE)
        else $error("left done state without last byte");

endmodule

@@ rtl/jsof_out_reg.sv @@
// ----------------------------------------------------------------------------
// jsof_out_reg
// Result register; holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module jsof_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  jsof_pkg::t_result i_res,
    output logic              o_can_take,
    output logic              o_valid,
    input  logic              i_ready,
    output jsof_pkg::t_result o_res
);
    import jsof_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ rtl/jpeg_sof_component_finder.sv @@
// ----------------------------------------------------------------------------
// jpeg_sof_component_finder
// Walks JPEG markers in a byte stream and reports the frame header
// component count.
// ----------------------------------------------------------------------------
// i_byte_ch carries one stream byte per item, with last_byte on the final
// byte of a stream. o_result_ch gives at most one result per stream: the
// component count of the first SOF0..SOF3 header (sof_found = 1), or a
// not-found result (sof_found = 0) when a segment length is below two or
// the stream ends first. Later bytes of that stream give nothing; the last
// byte rearms the scanner for the next stream.
// Throughput is one byte per cycle while the output register can take a
// result. An accepted byte is first held in the input register; the marker
// walker then updates its state and, if the byte completes a result, writes
// the output register, whose valid flag presents the result.
// Reset clears the valid flags of both registers and returns the walker to hunting for 0xFF.
// When the receiver stalls, the result holds in the output register and
// the input register keeps one more byte; i_byte_ch.ready then drops until
// the result is taken.
// ----------------------------------------------------------------------------
module jpeg_sof_component_finder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsof_in_if.sink    i_byte_ch,
    jsof_out_if.source o_result_ch
);
    import jsof_pkg::*;

    logic       stg_valid;
    logic [7:0] stg_data;
    logic       stg_last;
    logic       out_can_take;
    logic       fire;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign fire = stg_valid && out_can_take;

    jsof_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_byte_ch.valid),
        .i_data    (i_byte_ch.data_byte),
        .i_last    (i_byte_ch.last_byte),
        .o_ready   (i_byte_ch.ready),
        .i_advance (out_can_take),
        .o_valid   (stg_valid),
        .o_data    (stg_data),
        .o_last    (stg_last)
    );

    jsof_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data      (stg_data),
        .i_last      (stg_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    jsof_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .o_can_take (out_can_take),
        .o_valid    (o_result_ch.valid),
        .i_ready    (o_result_ch.ready),
        .o_res      (out_res)
    );

    assign o_result_ch.component_count = out_res.component_count;
    assign o_result_ch.is_color        = out_res.is_color;
    assign o_result_ch.sof_found       = out_res.sof_found;

endmodule
